// ===== hw/rtl/bezier_curve_evaluator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// bezier curve evaluator assertion macros
// shorthand for the concurrent checks on the top level ports
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_EVALUATOR_UNIT_ASSERT_SVH
`define BEZIER_CURVE_EVALUATOR_UNIT_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define BCEU_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("%m: check failed");

// next-cycle implication, quiet while in reset
`define BCEU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("%m: check failed");

// condition that must hold in the cycle after a reset edge
`define BCEU_ASSERT_AFTER_RESET(lbl, post) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (post)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// shared types and constants of the bezier curve evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

    localparam int MAX_POINTS  = 8;
    localparam int DIMENSIONS  = 3;
    localparam int COORD_WIDTH = 16;

    localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = 4;
    localparam int PCS_W   = $clog2(MAX_POINTS + 1) + 1;
    localparam int POINT_W = DIMENSIONS * COORD_WIDTH;

    // t is Q2.16, only 0..1.0 reaches the datapath
    localparam int T_W    = 18;
    localparam int TFRAC  = 16;
    localparam int TU_W   = TFRAC + 1;
    localparam int T_ONE  = 1 << TFRAC;

    // bernstein weights, unsigned with WFRAC fraction bits
    localparam int WFRAC  = 24;
    localparam int W_W    = WFRAC + 1;
    localparam int ELEV_W = TU_W + W_W + 1;
    localparam int PROD_W = W_W + 1 + COORD_WIDTH;
    localparam int ACC_W  = PROD_W + IDX_W;

    localparam logic [W_W-1:0] W_ONE   = {1'b1, {WFRAC{1'b0}}};
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (WFRAC - 1);

    // stream payload layout
    localparam int FIELD_W    = 16;
    localparam int OUT_FIELDS = 3;
    localparam int IN_IDX_LSB = 0;
    localparam int IN_IDX_W   = 3;
    localparam int IN_PT_LSB  = IN_IDX_LSB + IN_IDX_W;
    localparam int IN_T_LSB   = IN_PT_LSB + OUT_FIELDS * FIELD_W;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = OUT_FIELDS * FIELD_W;

    localparam logic [CNT_W-1:0] PC_RESET = CNT_W'(2);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_SKIP,
        KIND_EVAL,
        KIND_OOR
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [IDX_W-1:0]    index;
        logic [POINT_W-1:0]  point;
        logic [TU_W-1:0]     t;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEV,
        ST_ACC,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bce_front.sv =====
// ----------------------------------------------------------------------------
// bce_front
// unpacks input items and sorts them into point writes, evaluations and out-of-range evaluations
// ----------------------------------------------------------------------------
`default_nettype none

module bce_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bce_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tuser,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output bce_pkg::entry_t                     push_data
);

    logic [bce_pkg::IN_IDX_W-1:0] index;
    logic [bce_pkg::T_W-1:0]      t_raw;
    logic                         t_ok;
    logic                         idx_ok;

    assign index = s_tdata[bce_pkg::IN_IDX_LSB +: bce_pkg::IN_IDX_W];
    assign t_raw = s_tdata[bce_pkg::IN_T_LSB +: bce_pkg::T_W];

    // 0 <= t <= 1.0: sign clear and nothing above the one bit
    assign t_ok   = !t_raw[bce_pkg::T_W-1]
                  && !(t_raw[bce_pkg::TFRAC] && (|t_raw[bce_pkg::TFRAC-1:0]));
    assign idx_ok = 32'(index) < bce_pkg::MAX_POINTS;

    always_comb begin
        push_data.index = bce_pkg::IDX_W'(index);
        push_data.point = s_tdata[bce_pkg::IN_PT_LSB +: bce_pkg::POINT_W];
        push_data.t     = t_raw[bce_pkg::TU_W-1:0];
        if (s_tuser == bce_pkg::ACT_EVAL) begin
            push_data.kind = t_ok ? bce_pkg::KIND_EVAL : bce_pkg::KIND_OOR;
        end else begin
            push_data.kind = idx_ok ? bce_pkg::KIND_WRITE : bce_pkg::KIND_SKIP;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/bce_queue.sv =====
// ----------------------------------------------------------------------------
// bce_queue
// short first-in first-out queue between the front and the evaluation unit
// ----------------------------------------------------------------------------
`default_nettype none

module bce_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire bce_pkg::entry_t  push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output bce_pkg::entry_t       pop_data
);

    bce_pkg::entry_t              slot_reg [bce_pkg::Q_DEPTH];
    logic [bce_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [bce_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [bce_pkg::Q_CNT_W-1:0]  count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = 32'(count_reg) < bce_pkg::Q_DEPTH;
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bce_back.sv =====
// ----------------------------------------------------------------------------
// bce_back
// evaluation unit: point table, bernstein weight lanes and the accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module bce_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [bce_pkg::CNT_W-1:0]      point_count,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    input  wire bce_pkg::entry_t                q_data,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bce_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser
);

    bce_pkg::state_t state_reg, state_next;

    logic [bce_pkg::POINT_W-1:0]  mem [bce_pkg::MAX_POINTS];

    logic [bce_pkg::W_W-1:0]      w_reg  [bce_pkg::MAX_POINTS];
    logic [bce_pkg::W_W-1:0]      w_next [bce_pkg::MAX_POINTS];
    logic [bce_pkg::TU_W-1:0]     t_reg;
    logic [bce_pkg::TU_W-1:0]     u_reg;
    logic [bce_pkg::IDX_W-1:0]    n_reg;
    logic [bce_pkg::IDX_W-1:0]    step_reg;
    logic [bce_pkg::IDX_W-1:0]    rd_idx_reg;
    logic                         range_reg;

    logic                         p1_valid_reg;
    logic                         p2_valid_reg;
    logic [bce_pkg::POINT_W-1:0]  rd_point_reg;
    logic [bce_pkg::W_W-1:0]      w_sel_reg;
    logic signed [bce_pkg::PROD_W-1:0] prod_reg [bce_pkg::DIMENSIONS];
    logic signed [bce_pkg::ACC_W-1:0]  acc_reg  [bce_pkg::DIMENSIONS];

    logic                         m_valid_reg;
    logic [bce_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                         m_user_reg;

    logic                         take;
    logic                         mem_we;
    logic                         start;
    logic                         oor;
    logic                         elev_en;
    logic                         issue;
    logic                         load_out;

    logic [bce_pkg::PCS_W-1:0]    pc_sat;
    logic [bce_pkg::IDX_W-1:0]    n_calc;

    // degree n = clamped point count minus one
    always_comb begin
        if (point_count == '0) begin
            pc_sat = bce_pkg::PCS_W'(1);
        end else if (32'(point_count) > bce_pkg::MAX_POINTS) begin
            pc_sat = bce_pkg::PCS_W'(bce_pkg::MAX_POINTS);
        end else begin
            pc_sat = bce_pkg::PCS_W'(point_count);
        end
        n_calc = bce_pkg::IDX_W'(pc_sat - bce_pkg::PCS_W'(1));
    end

    // ------------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bce_pkg::ST_IDLE: begin
                if (q_valid && q_data.kind == bce_pkg::KIND_EVAL) begin
                    state_next = bce_pkg::ST_ELEV;
                end else if (q_valid && q_data.kind == bce_pkg::KIND_OOR) begin
                    state_next = bce_pkg::ST_DONE;
                end
            end
            bce_pkg::ST_ELEV: begin
                if (step_reg == n_reg) begin
                    state_next = bce_pkg::ST_ACC;
                end
            end
            bce_pkg::ST_ACC: begin
                if (rd_idx_reg == n_reg) begin
                    state_next = bce_pkg::ST_DRAIN;
                end
            end
            bce_pkg::ST_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) begin
                    state_next = bce_pkg::ST_DONE;
                end
            end
            bce_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = bce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bce_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        q_ready  = state_reg == bce_pkg::ST_IDLE;
        take     = q_valid && q_ready;
        mem_we   = take && q_data.kind == bce_pkg::KIND_WRITE;
        start    = take && q_data.kind == bce_pkg::KIND_EVAL;
        oor      = take && q_data.kind == bce_pkg::KIND_OOR;
        elev_en  = state_reg == bce_pkg::ST_ELEV && step_reg != n_reg;
        issue    = state_reg == bce_pkg::ST_ACC;
        load_out = state_reg == bce_pkg::ST_DONE && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bce_pkg::ST_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // weight lanes: one degree elevation per cycle across all lanes
    // ------------------------------------------------------------------------
    always_comb begin
        logic [bce_pkg::W_W-1:0]    prev;
        logic [bce_pkg::ELEV_W-1:0] mul_u;
        logic [bce_pkg::ELEV_W-1:0] mul_t;
        for (int i = 0; i < bce_pkg::MAX_POINTS; i++) begin
            prev  = (i == 0) ? '0 : w_reg[(i == 0) ? 0 : i - 1];
            mul_u = bce_pkg::ELEV_W'(u_reg) * bce_pkg::ELEV_W'(w_reg[i]);
            mul_t = bce_pkg::ELEV_W'(t_reg) * bce_pkg::ELEV_W'(prev);
            w_next[i] = bce_pkg::W_W'((mul_u + mul_t) >> bce_pkg::TFRAC);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            t_reg      <= q_data.t;
            u_reg      <= bce_pkg::TU_W'(bce_pkg::T_ONE) - q_data.t;
            n_reg      <= n_calc;
            step_reg   <= '0;
            rd_idx_reg <= '0;
            range_reg  <= 1'b1;
            for (int i = 0; i < bce_pkg::MAX_POINTS; i++) begin
                w_reg[i] <= (i == 0) ? bce_pkg::W_ONE : '0;
            end
        end else begin
            if (oor) begin
                range_reg <= 1'b0;
            end
            if (elev_en) begin
                w_reg    <= w_next;
                step_reg <= step_reg + 1'b1;
            end
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // point table and multiply-accumulate pipe
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_data.index] <= q_data.point;
        end
        if (issue) begin
            rd_point_reg <= mem[rd_idx_reg];
            w_sel_reg    <= w_reg[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        for (int d = 0; d < bce_pkg::DIMENSIONS; d++) begin
            if (p1_valid_reg) begin
                prod_reg[d] <= $signed({1'b0, w_sel_reg})
                             * $signed(rd_point_reg[d*bce_pkg::COORD_WIDTH +:
                                                    bce_pkg::COORD_WIDTH]);
            end
            if (start) begin
                acc_reg[d] <= '0;
            end else if (p2_valid_reg) begin
                acc_reg[d] <= acc_reg[d] + bce_pkg::ACC_W'(prod_reg[d]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result register: round half up and drop the weight fraction
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        logic [bce_pkg::ACC_W-1:0]     rounded;
        logic [bce_pkg::M_TDATA_W-1:0] data;
        if (load_out) begin
            data = '0;
            for (int d = 0; d < bce_pkg::DIMENSIONS; d++) begin
                rounded = acc_reg[d] + bce_pkg::ROUND_HALF;
                if (range_reg) begin
                    data[d*bce_pkg::FIELD_W +: bce_pkg::FIELD_W] =
                        bce_pkg::FIELD_W'(rounded[bce_pkg::WFRAC +: bce_pkg::COORD_WIDTH]);
                end
            end
            m_user_reg <= range_reg;
            m_data_reg <= data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bezier_curve_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_evaluator_unit
// bernstein-form bezier curve evaluation over a table of control points
// ----------------------------------------------------------------------------
// s_ channel: tuser selects the action (0 write a control point, 1 evaluate).
//   a write stores three Q7.8 coordinates at point_index and gives no result;
//   an evaluation takes t in Q2.16 and gives one item on the m_ channel.
// m_ channel: tuser is in_range, tdata the curve point; t outside 0..1.0
//   gives in_range 0 and zero coordinates.
// cfg channel: point_count (1..8, curve degree plus one), reset value 2,
//   always ready; the user must write it only while the block is idle, which the block does not enforce.
// items pass through a four-entry queue into the evaluation unit, which takes
//   no new item until it is idle again. an evaluation runs weight elevation
//   (all lanes in parallel), then table reads with one point accumulated per
//   cycle, then the multiply/accumulate pipe drain. an accepted item is
//   registered in the queue before the unit can take it.
// reset empties the queue and drops any result; the point table keeps its
//   contents and must be written before it is read.
// a stalled receiver holds the result register; the queue keeps accepting
//   items until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_evaluator_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // tdata: point_index[2:0], coord_x[18:3], coord_y[34:19], coord_z[50:35],
    //        t[68:51], zero fill[71:69]
    input  wire logic [bce_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: action
    input  wire logic                           s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata: out_x[15:0], out_y[31:16], out_z[47:32]
    output logic [bce_pkg::M_TDATA_W-1:0]       m_tdata,
    // tuser: in_range
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [bce_pkg::CNT_W-1:0]      cfg_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready
);

    logic [bce_pkg::CNT_W-1:0] point_count_reg;

    logic             push_valid;
    logic             push_ready;
    bce_pkg::entry_t  push_data;
    logic             pop_valid;
    logic             pop_ready;
    bce_pkg::entry_t  pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= bce_pkg::PC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            point_count_reg <= cfg_data;
        end
    end

    bce_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bce_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .point_count (point_count_reg),
        .q_valid     (pop_valid),
        .q_ready     (pop_ready),
        .q_data      (pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bce_checker.sv =====
// ----------------------------------------------------------------------------
// bce_checker
// port-level checks of the bezier curve evaluator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bezier_curve_evaluator_unit_assert.svh"

module bce_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic [bce_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           m_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready
);

    // a stalled result stays put
    `BCEU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // t out of range always comes back as a zero point
    `BCEU_ASSERT_SAME(a_oor_zero, m_tvalid && !m_tuser, m_tdata == '0)

    // reset leaves no result pending and an empty queue
    `BCEU_ASSERT_AFTER_RESET(a_reset_clean, !m_tvalid && s_tready)

endmodule

bind bezier_curve_evaluator_unit bce_checker u_bce_checker (.*);

`default_nettype wire
